@@ rtl/hrp_pkg.sv @@
// package for the http response header parser
// field widths, types, character constants and match text imported by the other rtl files
`timescale 1ns / 1ps

package hrp_pkg;

    localparam int unsigned C_BYTE_W   = 8;
    localparam int unsigned C_STATUS_W = 16;
    localparam int unsigned C_LENGTH_W = 32;
    localparam int unsigned C_COUNT_W  = 32;
    localparam int unsigned C_RESULT_W = 2;

    localparam logic [C_COUNT_W-1:0] C_BODY_LIMIT_RESET = 32'd4096;

    localparam logic [7:0] C_CHAR_LF    = 8'h0A;
    localparam logic [7:0] C_CHAR_CR    = 8'h0D;
    localparam logic [7:0] C_CHAR_SPACE = 8'h20;
    localparam logic [7:0] C_CHAR_TAB   = 8'h09;
    localparam logic [7:0] C_CHAR_ZERO  = 8'h30;
    localparam logic [7:0] C_CHAR_NINE  = 8'h39;
    localparam logic [7:0] C_CHAR_H     = 8'h48;
    localparam logic [7:0] C_CHAR_C     = 8'h43;

    localparam logic [2:0] C_MARKER_LEN = 3'd4;
    localparam logic [4:0] C_KEY_LEN    = 5'd16;

    typedef enum logic [1:0] {
        RES_MORE   = 2'd0,
        RES_DONE   = 2'd1,
        RES_REJECT = 2'd2
    } t_result_code;

    typedef enum logic [1:0] {
        ST_WAIT_SPACE = 2'd0,
        ST_DIGITS     = 2'd1,
        ST_CLOSED     = 2'd2
    } t_status_phase;

    typedef enum logic [1:0] {
        LEN_KEY    = 2'd0,
        LEN_PRE    = 2'd1,
        LEN_DIGITS = 2'd2,
        LEN_CLOSED = 2'd3
    } t_length_phase;

    typedef struct packed {
        logic [2:0]            marker_pos;
        logic                  marker_seen;
        t_status_phase         status_phase;
        logic [C_STATUS_W-1:0] status_value;
        logic [4:0]            key_pos;
        t_length_phase         length_phase;
        logic [C_LENGTH_W-1:0] length_value;
    } t_scan_state;

    localparam t_scan_state C_SCAN_RESET = '{
        marker_pos:   3'd0,
        marker_seen:  1'b0,
        status_phase: ST_WAIT_SPACE,
        status_value: 16'd0,
        key_pos:      5'd0,
        length_phase: LEN_KEY,
        length_value: 32'd0
    };

    function automatic logic [7:0] f_marker_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0: ch = 8'h48;
            2'd1: ch = 8'h54;
            2'd2: ch = 8'h54;
            default: ch = 8'h50;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] f_key_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:  ch = 8'h43;
            4'd1:  ch = 8'h6F;
            4'd2:  ch = 8'h6E;
            4'd3:  ch = 8'h74;
            4'd4:  ch = 8'h65;
            4'd5:  ch = 8'h6E;
            4'd6:  ch = 8'h74;
            4'd7:  ch = 8'h2D;
            4'd8:  ch = 8'h4C;
            4'd9:  ch = 8'h65;
            4'd10: ch = 8'h6E;
            4'd11: ch = 8'h67;
            4'd12: ch = 8'h74;
            4'd13: ch = 8'h68;
            4'd14: ch = 8'h3A;
            default: ch = 8'h20;
        endcase
        return ch;
    endfunction

    function automatic logic f_is_digit(input logic [7:0] ch);
        return (ch >= C_CHAR_ZERO) && (ch <= C_CHAR_NINE);
    endfunction

endpackage

@@ rtl/hrp_in_if.sv @@
// input byte channel of the http response header parser
// depends on hrp_pkg for field widths
`timescale 1ns / 1ps

interface hrp_in_if
    import hrp_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [C_BYTE_W-1:0] data_byte;
    logic                new_response;

    modport source (output valid, output data_byte, output new_response, input ready);
    modport sink   (input valid, input data_byte, input new_response, output ready);
endinterface

@@ rtl/hrp_out_if.sv @@
// result channel of the http response header parser
// depends on hrp_pkg for field widths
`timescale 1ns / 1ps

interface hrp_out_if
    import hrp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [C_RESULT_W-1:0] result_code;
    logic                  header_done;
    logic [C_STATUS_W-1:0] status_code;
    logic [C_LENGTH_W-1:0] content_length;

    modport source (output valid, output result_code, output header_done,
                    output status_code, output content_length, input ready);
    modport sink   (input valid, input result_code, input header_done,
                    input status_code, input content_length, output ready);
endinterface

@@ rtl/hrp_header_scan.sv @@
// header matcher next-state logic: marker, status number, content length key and value
// depends on hrp_pkg
`timescale 1ns / 1ps

module hrp_header_scan
    import hrp_pkg::*;
(
    input  t_scan_state         i_state,
    input  logic [C_BYTE_W-1:0] i_byte,
    output t_scan_state         o_state
);

    logic                    w_digit;
    logic [3:0]              w_digit_val;
    logic [C_STATUS_W+3:0]   w_status_acc;
    logic [C_LENGTH_W+3:0]   w_length_acc;
    logic [C_STATUS_W-1:0]   w_status_sat;
    logic [C_LENGTH_W-1:0]   w_length_sat;

    assign w_digit     = f_is_digit(i_byte);
    assign w_digit_val = i_byte[3:0];

    // value * 10 + digit
    assign w_status_acc = ({4'd0, i_state.status_value} << 3)
                        + ({4'd0, i_state.status_value} << 1)
                        + {{C_STATUS_W{1'b0}}, w_digit_val};
    assign w_length_acc = ({4'd0, i_state.length_value} << 3)
                        + ({4'd0, i_state.length_value} << 1)
                        + {{C_LENGTH_W{1'b0}}, w_digit_val};

    assign w_status_sat = (w_status_acc[C_STATUS_W+3:C_STATUS_W] != 4'd0)
                        ? {C_STATUS_W{1'b1}} : w_status_acc[C_STATUS_W-1:0];
    assign w_length_sat = (w_length_acc[C_LENGTH_W+3:C_LENGTH_W] != 4'd0)
                        ? {C_LENGTH_W{1'b1}} : w_length_acc[C_LENGTH_W-1:0];

    always_comb begin
        o_state = i_state;

        if (!i_state.marker_seen) begin
            if ((i_state.marker_pos != C_MARKER_LEN)
                && (i_byte == f_marker_char(i_state.marker_pos[1:0]))) begin
                o_state.marker_pos = 3'(i_state.marker_pos + 3'd1);
                if (i_state.marker_pos == 3'(C_MARKER_LEN - 3'd1)) begin
                    o_state.marker_seen = 1'b1;
                end
            end else begin
                o_state.marker_pos = (i_byte == C_CHAR_H) ? 3'd1 : 3'd0;
            end
        end

        case (i_state.status_phase)
            ST_WAIT_SPACE: begin
                if (i_byte == C_CHAR_SPACE) begin
                    o_state.status_phase = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (w_digit) begin
                    o_state.status_value = w_status_sat;
                end else begin
                    o_state.status_phase = ST_CLOSED;
                end
            end
            default: begin
            end
        endcase

        case (i_state.length_phase)
            LEN_KEY: begin
                if ((i_state.key_pos != C_KEY_LEN)
                    && (i_byte == f_key_char(i_state.key_pos[3:0]))) begin
                    o_state.key_pos = 5'(i_state.key_pos + 5'd1);
                    if (i_state.key_pos == 5'(C_KEY_LEN - 5'd1)) begin
                        o_state.length_phase = LEN_PRE;
                    end
                end else begin
                    o_state.key_pos = (i_byte == C_CHAR_C) ? 5'd1 : 5'd0;
                end
            end
            LEN_PRE, LEN_DIGITS: begin
                if (i_byte == C_CHAR_CR) begin
                    o_state.length_phase = i_state.length_phase;
                end else if (w_digit) begin
                    o_state.length_value = w_length_sat;
                    o_state.length_phase = LEN_DIGITS;
                end else if ((i_state.length_phase == LEN_PRE)
                             && ((i_byte == C_CHAR_SPACE) || (i_byte == C_CHAR_TAB))) begin
                    o_state.length_phase = LEN_PRE;
                end else begin
                    o_state.length_phase = LEN_CLOSED;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/http_response_header_parser_unit.sv @@
// http response header parser: result registered on each byte transaction
// throughput one byte per cycle while the sink accepts results; set by the
// single update between the parse state registers and the result register,
// which holds while the sink stalls; synchronous active-low reset clears parse
// state, drops result valid and loads body_limit with 4096
// depends on hrp_pkg, hrp_in_if, hrp_out_if, hrp_header_scan
`timescale 1ns / 1ps

module http_response_header_parser_unit
    import hrp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hrp_in_if.sink               i_in,
    hrp_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [C_COUNT_W-1:0] i_cfg_wdata
);

    logic                  r_in_body;
    logic                  r_blank_pending;
    t_scan_state           r_scan;
    logic [C_COUNT_W-1:0]  r_body_count;
    logic [C_COUNT_W-1:0]  r_body_limit;

    logic                  r_out_valid;
    t_result_code          r_result;
    logic                  r_header_done;
    logic [C_STATUS_W-1:0] r_status;
    logic [C_LENGTH_W-1:0] r_length;

    logic                  n_in_body;
    logic                  n_blank_pending;
    t_scan_state           n_scan;
    logic [C_COUNT_W-1:0]  n_body_count;
    t_result_code          n_result;

    logic                  w_fire;
    logic                  w_base_in_body;
    logic                  w_base_blank;
    t_scan_state           w_base_scan;
    logic [C_COUNT_W-1:0]  w_base_count;
    t_scan_state           w_fed_scan;
    logic                  w_ends;
    logic [C_BYTE_W-1:0]   w_byte;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_fire     = i_in.valid && i_in.ready;
    assign w_byte     = i_in.data_byte;

    // new response clears parse state before the byte is taken
    assign w_base_in_body = i_in.new_response ? 1'b0 : r_in_body;
    assign w_base_blank   = i_in.new_response ? 1'b0 : r_blank_pending;
    assign w_base_scan    = i_in.new_response ? C_SCAN_RESET : r_scan;
    assign w_base_count   = i_in.new_response ? {C_COUNT_W{1'b0}} : r_body_count;

    hrp_header_scan u_scan (
        .i_state (w_base_scan),
        .i_byte  (w_byte),
        .o_state (w_fed_scan)
    );

    always_comb begin
        n_in_body       = w_base_in_body;
        n_blank_pending = w_base_blank;
        n_scan          = w_base_scan;
        n_body_count    = w_base_count;
        n_result        = RES_MORE;
        w_ends          = 1'b0;

        if (!w_base_in_body) begin
            if (w_byte == C_CHAR_LF) begin
                if (w_base_blank) begin
                    w_ends = 1'b1;
                end else begin
                    n_blank_pending = 1'b1;
                end
            end else if (w_base_blank && (w_byte != C_CHAR_CR)) begin
                n_blank_pending = 1'b0;
            end

            if (w_ends) begin
                n_in_body = 1'b1;
                if (!w_base_scan.marker_seen) begin
                    n_scan.status_value = '0;
                    n_scan.length_value = '0;
                end
                if (n_scan.length_value == '0) begin
                    n_result = RES_DONE;
                end
            end else begin
                n_scan = w_fed_scan;
            end
        end else begin
            if (w_base_count != {C_COUNT_W{1'b1}}) begin
                n_body_count = C_COUNT_W'(w_base_count + 1'b1);
            end
            if ((w_base_scan.length_value != '0)
                && (n_body_count >= w_base_scan.length_value)) begin
                n_result = RES_DONE;
            end else if (n_body_count > r_body_limit) begin
                n_result = RES_REJECT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body       <= 1'b0;
            r_blank_pending <= 1'b0;
            r_scan          <= C_SCAN_RESET;
            r_body_count    <= '0;
            r_body_limit    <= C_BODY_LIMIT_RESET;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_body_limit <= i_cfg_wdata;
            end
            if (w_fire) begin
                r_in_body       <= n_in_body;
                r_blank_pending <= n_blank_pending;
                r_scan          <= n_scan;
                r_body_count    <= n_body_count;
                r_out_valid     <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result      <= n_result;
            r_header_done <= n_in_body;
            r_status      <= n_in_body ? n_scan.status_value : '0;
            r_length      <= n_in_body ? n_scan.length_value : '0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_code    = r_result;
    assign o_out.header_done    = r_header_done;
    assign o_out.status_code    = r_status;
    assign o_out.content_length = r_length;

    a_no_result_before_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_header_done) |-> (r_result == RES_MORE))
        else $error("result reported before header end");

    a_zero_fields_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_header_done) |-> ((r_status == '0) && (r_length == '0)))
        else $error("status or length shown before header end");

    a_body_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_body && !i_in.new_response) |=> r_in_body)
        else $error("left body without a new response");

    a_count_only_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_body |-> (r_body_count == '0))
        else $error("body count moved during header");

    a_reject_over_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (n_result == RES_REJECT)) |-> (n_body_count > r_body_limit))
        else $error("reject without exceeding limit");

endmodule
